### rtl/core/viewdata_row_attribute_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the viewdata row attribute decoder
// Clocked on clk and disabled while arst_n is low; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef VIEWDATA_ROW_ATTRIBUTE_DECODER_MACROS_SVH
`define VIEWDATA_ROW_ATTRIBUTE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define VRAD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("vrad: property violated");
`define VRAD_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("vrad: forbidden condition seen");
`else
`define VRAD_ASSERT(lbl, prop)
`define VRAD_ASSERT_NEVER(lbl, cond)
`endif

`endif

### rtl/core/vrad_pkg.sv
// ----------------------------------------------------------------------------
// vrad_pkg
// Types and control code constants shared by the row attribute decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrad_pkg;

	// C1 control codes, full 7-bit value
	localparam logic [6:0] CODE_BASE      = 7'h40;
	localparam logic [6:0] CODE_FLASH     = 7'h48;
	localparam logic [6:0] CODE_STEADY    = 7'h49;
	localparam logic [6:0] CODE_NORMAL_HT = 7'h4C;
	localparam logic [6:0] CODE_DOUBLE_HT = 7'h4D;
	localparam logic [6:0] CODE_CONCEAL   = 7'h58;
	localparam logic [6:0] CODE_CONTIG    = 7'h59;
	localparam logic [6:0] CODE_SEPARATED = 7'h5A;
	localparam logic [6:0] CODE_BLACK_BG  = 7'h5C;
	localparam logic [6:0] CODE_NEW_BG    = 7'h5D;
	localparam logic [6:0] CODE_HOLD      = 7'h5E;
	localparam logic [6:0] CODE_RELEASE   = 7'h5F;

	// upper nibble of the alpha and mosaic colour code groups
	localparam logic [3:0] GRP_ALPHA_COLOUR  = 4'h8;
	localparam logic [3:0] GRP_MOSAIC_COLOUR = 4'hA;

	localparam logic [6:0] SPACE_SLOT   = 7'h20;
	localparam logic [2:0] COLOUR_WHITE = 3'd7;
	localparam logic [2:0] COLOUR_BLACK = 3'd0;

	typedef struct packed {
		logic [2:0] fg_colour;
		logic [2:0] bg_colour;
		logic       graphics_mode;
		logic       flash_on;
		logic       conceal_on;
		logic       separated_on;
		logic       hold_on;
		logic [6:0] held_glyph;
		logic       held_valid;
		logic       double_flag;
	} attr_state_t;

	localparam attr_state_t ATTR_DEFAULTS = '{
		fg_colour:     COLOUR_WHITE,
		bg_colour:     COLOUR_BLACK,
		graphics_mode: 1'b0,
		flash_on:      1'b0,
		conceal_on:    1'b0,
		separated_on:  1'b0,
		hold_on:       1'b0,
		held_glyph:    7'd0,
		held_valid:    1'b0,
		double_flag:   1'b0
	};

	typedef struct packed {
		logic       row_start;
		logic       is_control;
		logic [4:0] control_code;
		logic [6:0] cell_char;
	} cell_in_t;

	typedef struct packed {
		logic [6:0] glyph_slot;
		logic       mosaic_font;
		logic       blink;
		logic [2:0] fore_colour;
		logic [2:0] back_colour;
		logic       double_seen;
	} cell_out_t;

endpackage

### rtl/core/vrad_cell_logic.sv
// ----------------------------------------------------------------------------
// vrad_cell_logic
// Per-cell attribute update and render decision: current state plus one cell
// in, next state and the cell's display attributes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrad_cell_logic (
	input  vrad_pkg::attr_state_t cur_state,
	input  vrad_pkg::cell_in_t    cell_in,
	output vrad_pkg::attr_state_t nxt_state,
	output vrad_pkg::cell_out_t   result
);

	vrad_pkg::attr_state_t s;
	vrad_pkg::attr_state_t n;
	logic [6:0] code;
	logic       show_hold;
	logic [6:0] mosaic_glyph;

	assign s    = cell_in.row_start ? vrad_pkg::ATTR_DEFAULTS : cur_state;
	assign code = vrad_pkg::CODE_BASE | {2'b00, cell_in.control_code};
	// pattern is byte minus 0x20 or 0x40; separated adds 0x40
	assign mosaic_glyph = {s.separated_on, cell_in.cell_char[6], cell_in.cell_char[4:0]};
	assign nxt_state = n;

	always_comb begin
		n         = s;
		show_hold = 1'b0;
		result    = '0;
		if (cell_in.is_control) begin
			priority if (code[6:3] == vrad_pkg::GRP_ALPHA_COLOUR) begin
				// alpha black keeps the foreground
				if (code[2:0] != 3'd0) begin
					n.fg_colour = code[2:0];
				end
				n.graphics_mode = 1'b0;
				n.conceal_on    = 1'b0;
				n.held_glyph    = 7'd0;
				n.held_valid    = 1'b0;
			end else if (code[6:3] == vrad_pkg::GRP_MOSAIC_COLOUR && code[2:0] != 3'd0) begin
				n.fg_colour     = code[2:0];
				n.graphics_mode = 1'b1;
				n.conceal_on    = 1'b0;
				if (!s.hold_on) begin
					n.held_glyph = 7'd0;
					n.held_valid = 1'b0;
				end
			end else begin
				unique case (code)
					vrad_pkg::CODE_FLASH:     n.flash_on = 1'b1;
					vrad_pkg::CODE_STEADY:    n.flash_on = 1'b0;
					vrad_pkg::CODE_NORMAL_HT: begin
						n.held_glyph = 7'd0;
						n.held_valid = 1'b0;
					end
					vrad_pkg::CODE_DOUBLE_HT: begin
						n.double_flag = 1'b1;
						n.held_glyph  = 7'd0;
						n.held_valid  = 1'b0;
					end
					vrad_pkg::CODE_CONCEAL:   n.conceal_on   = 1'b1;
					vrad_pkg::CODE_CONTIG:    n.separated_on = 1'b0;
					vrad_pkg::CODE_SEPARATED: n.separated_on = 1'b1;
					vrad_pkg::CODE_BLACK_BG:  n.bg_colour    = vrad_pkg::COLOUR_BLACK;
					vrad_pkg::CODE_NEW_BG:    n.bg_colour    = s.fg_colour;
					vrad_pkg::CODE_HOLD:      n.hold_on      = 1'b1;
					vrad_pkg::CODE_RELEASE:   n.hold_on      = 1'b0;
					default: ;
				endcase
			end

			// hold graphics takes effect at its own cell
			show_hold = (code == vrad_pkg::CODE_HOLD) ? n.hold_on : s.hold_on;
			if (show_hold && n.graphics_mode && n.held_valid) begin
				result.glyph_slot  = n.held_glyph;
				result.mosaic_font = 1'b1;
			end else begin
				result.glyph_slot  = vrad_pkg::SPACE_SLOT;
				result.mosaic_font = 1'b0;
			end
			result.blink       = s.flash_on;
			result.fore_colour = s.conceal_on ? s.bg_colour : s.fg_colour;
			result.back_colour = (code == vrad_pkg::CODE_BLACK_BG || code == vrad_pkg::CODE_NEW_BG)
			                     ? n.bg_colour : s.bg_colour;
		end else begin
			result.glyph_slot  = cell_in.cell_char;
			result.mosaic_font = 1'b0;
			// bytes with bit 5 set are mosaics; the rest pass through as alpha
			if (s.graphics_mode && cell_in.cell_char[5]) begin
				result.glyph_slot  = mosaic_glyph;
				result.mosaic_font = 1'b1;
				n.held_glyph       = mosaic_glyph;
				n.held_valid       = 1'b1;
			end
			result.blink       = s.flash_on;
			result.fore_colour = s.conceal_on ? s.bg_colour : s.fg_colour;
			result.back_colour = s.bg_colour;
		end
		result.double_seen = n.double_flag;
	end

endmodule

### rtl/core/viewdata_row_attribute_decoder.sv
// ----------------------------------------------------------------------------
// viewdata_row_attribute_decoder
// Serial attribute decoder for one viewdata row: one character cell per beat
// in, one set of display attributes per beat out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | sink      | in_valid / in_stall  | row_start is_control control_code cell_char
//  out     | source    | out_valid / out_stall| glyph_slot mosaic_font blink fore_colour
//          |           |                      | back_colour double_seen
//
//  One beat per cycle sustained while out_stall is low; a cell is taken into the
//  input register, and when it advances its result passes through the attribute
//  logic into the result register, from which the result beat is offered.
//  The attribute state updates as a cell moves to the result register.
//  Reset sets the state to row defaults and empties both stages.
//  A stalled output holds its beat; the input register still takes one beat
//  while the result register waits, then in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "viewdata_row_attribute_decoder_macros.svh"

module viewdata_row_attribute_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       row_start,
	input  logic       is_control,
	input  logic [4:0] control_code,
	input  logic [6:0] cell_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] glyph_slot,
	output logic       mosaic_font,
	output logic       blink,
	output logic [2:0] fore_colour,
	output logic [2:0] back_colour,
	output logic       double_seen
);

	logic                  valid_s1;
	vrad_pkg::cell_in_t    cell_s1;
	vrad_pkg::attr_state_t state_q;
	vrad_pkg::attr_state_t state_nxt;
	vrad_pkg::cell_out_t   result_nxt;
	vrad_pkg::cell_out_t   result_q;
	logic                  out_valid_q;
	logic                  advance;
	logic                  accept;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= '{row_start: row_start, is_control: is_control,
			             control_code: control_code, cell_char: cell_char};
		end
	end

	vrad_cell_logic u_cell_logic (
		.cur_state (state_q),
		.cell_in   (cell_s1),
		.nxt_state (state_nxt),
		.result    (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vrad_pkg::ATTR_DEFAULTS;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				// drop the delivered beat
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign glyph_slot  = result_q.glyph_slot;
	assign mosaic_font = result_q.mosaic_font;
	assign blink       = result_q.blink;
	assign fore_colour = result_q.fore_colour;
	assign back_colour = result_q.back_colour;
	assign double_seen = result_q.double_seen;

	`VRAD_ASSERT(a_state_only_on_advance, !advance |=> $stable(state_q))
	`VRAD_ASSERT(a_advance_fills_output, advance |=> out_valid)
	`VRAD_ASSERT(a_taken_beat_clears, out_valid && !out_stall && !advance |=> !out_valid)
	`VRAD_ASSERT_NEVER(a_stall_needs_item, in_stall && !valid_s1)
	`VRAD_ASSERT_NEVER(a_stall_needs_out_stall, in_stall && !out_stall)

endmodule

### bench/viewdata_row_attribute_decoder_test.sv
// ----------------------------------------------------------------------------
// viewdata_row_attribute_decoder_test
// Streams character cells through the row attribute decoder and checks every
// result beat against an in-bench attribute predictor. Directed rows cover the
// set-at and set-after codes, held mosaics and colour handling; random rows and
// noise run with random idle bursts on both channels, then rows at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module viewdata_row_attribute_decoder_test;

	// control codes with no package name
	localparam logic [6:0] CODE_END_BOX      = 7'h4A;
	localparam logic [6:0] CODE_START_BOX    = 7'h4B;
	localparam logic [6:0] CODE_SPARE_4E     = 7'h4E;
	localparam logic [6:0] CODE_SPARE_4F     = 7'h4F;
	localparam logic [6:0] CODE_MOSAIC_BLACK = 7'h50;
	localparam logic [6:0] CODE_ESCAPE       = 7'h5B;

	localparam logic [6:0] MOSAIC_SEP_OFFSET = 7'h40;
	localparam int         CYCLE_LIMIT       = 200000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       row_start;
	logic       is_control;
	logic [4:0] control_code;
	logic [6:0] cell_char;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] glyph_slot;
	logic       mosaic_font;
	logic       blink;
	logic [2:0] fore_colour;
	logic [2:0] back_colour;
	logic       double_seen;

	vrad_pkg::attr_state_t row_attr;
	vrad_pkg::cell_out_t   expected_attrs[$];
	int                    mismatches;
	int                    cycles;
	int                    gap_pct;
	int                    stall_pct;

	viewdata_row_attribute_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row_start    (row_start),
		.is_control   (is_control),
		.control_code (control_code),
		.cell_char    (cell_char),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.glyph_slot   (glyph_slot),
		.mosaic_font  (mosaic_font),
		.blink        (blink),
		.fore_colour  (fore_colour),
		.back_colour  (back_colour),
		.double_seen  (double_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Advance the row attributes by one cell and work out what it displays.
	task automatic decode_attrs(input vrad_pkg::cell_in_t c, output vrad_pkg::cell_out_t r);
		vrad_pkg::attr_state_t prev;
		logic [6:0]            code;
		logic [6:0]            pattern;
		logic                  show_hold;
		if (c.row_start)
			row_attr = vrad_pkg::ATTR_DEFAULTS;
		prev = row_attr;
		if (c.is_control) begin
			code = vrad_pkg::CODE_BASE + 7'(c.control_code);
			if (code[6:3] == vrad_pkg::GRP_ALPHA_COLOUR) begin
				// alpha black keeps the foreground
				if (code != vrad_pkg::CODE_BASE)
					row_attr.fg_colour = code[2:0];
				row_attr.graphics_mode = 1'b0;
				row_attr.conceal_on = 1'b0;
				row_attr.held_glyph = '0;
				row_attr.held_valid = 1'b0;
			end else if (code[6:3] == vrad_pkg::GRP_MOSAIC_COLOUR
			             && code != CODE_MOSAIC_BLACK) begin
				row_attr.fg_colour = code[2:0];
				row_attr.graphics_mode = 1'b1;
				row_attr.conceal_on = 1'b0;
				if (!row_attr.hold_on) begin
					row_attr.held_glyph = '0;
					row_attr.held_valid = 1'b0;
				end
			end else begin
				unique case (code)
					vrad_pkg::CODE_FLASH: row_attr.flash_on = 1'b1;
					vrad_pkg::CODE_STEADY: row_attr.flash_on = 1'b0;
					vrad_pkg::CODE_NORMAL_HT: begin
						row_attr.held_glyph = '0;
						row_attr.held_valid = 1'b0;
					end
					vrad_pkg::CODE_DOUBLE_HT: begin
						row_attr.double_flag = 1'b1;
						row_attr.held_glyph = '0;
						row_attr.held_valid = 1'b0;
					end
					vrad_pkg::CODE_CONCEAL: row_attr.conceal_on = 1'b1;
					vrad_pkg::CODE_CONTIG: row_attr.separated_on = 1'b0;
					vrad_pkg::CODE_SEPARATED: row_attr.separated_on = 1'b1;
					vrad_pkg::CODE_BLACK_BG: row_attr.bg_colour = vrad_pkg::COLOUR_BLACK;
					vrad_pkg::CODE_NEW_BG: row_attr.bg_colour = row_attr.fg_colour;
					vrad_pkg::CODE_HOLD: row_attr.hold_on = 1'b1;
					vrad_pkg::CODE_RELEASE: row_attr.hold_on = 1'b0;
					default: ;
				endcase
			end
			// hold graphics acts at its own cell, release only after it
			show_hold = (code == vrad_pkg::CODE_HOLD) ? row_attr.hold_on : prev.hold_on;
			if (show_hold && row_attr.graphics_mode && row_attr.held_valid) begin
				r.glyph_slot = row_attr.held_glyph;
				r.mosaic_font = 1'b1;
			end else begin
				r.glyph_slot = vrad_pkg::SPACE_SLOT;
				r.mosaic_font = 1'b0;
			end
			r.blink = prev.flash_on;
			r.fore_colour = prev.conceal_on ? prev.bg_colour : prev.fg_colour;
			r.back_colour = (code == vrad_pkg::CODE_BLACK_BG || code == vrad_pkg::CODE_NEW_BG) ?
				row_attr.bg_colour : prev.bg_colour;
		end else begin
			r.glyph_slot = c.cell_char;
			r.mosaic_font = 1'b0;
			// bytes with bit 5 set are sixels; the rest pass through as alpha
			if (row_attr.graphics_mode && c.cell_char[5]) begin
				pattern = c.cell_char[6] ? c.cell_char - 7'h40 : c.cell_char - 7'h20;
				if (row_attr.separated_on)
					pattern = pattern + MOSAIC_SEP_OFFSET;
				r.glyph_slot = pattern;
				r.mosaic_font = 1'b1;
				row_attr.held_glyph = pattern;
				row_attr.held_valid = 1'b1;
			end
			r.blink = row_attr.flash_on;
			r.fore_colour = row_attr.conceal_on ? row_attr.bg_colour : row_attr.fg_colour;
			r.back_colour = row_attr.bg_colour;
		end
		r.double_seen = row_attr.double_flag;
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// Called at a rising edge; returns at the edge that takes the beat.
	task automatic send_cell(input vrad_pkg::cell_in_t c);
		vrad_pkg::cell_out_t r;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_start <= c.row_start;
		is_control <= c.is_control;
		control_code <= c.control_code;
		cell_char <= c.cell_char;
		do
			@(posedge clk);
		while (in_stall);
		decode_attrs(c, r);
		expected_attrs.push_back(r);
	endtask

	function automatic vrad_pkg::cell_in_t control_beat(input logic rs, input logic [6:0] code);
		vrad_pkg::cell_in_t b;
		b.row_start = rs;
		b.is_control = 1'b1;
		b.control_code = 5'(code - vrad_pkg::CODE_BASE);
		b.cell_char = 7'($urandom_range(0, 127));
		return b;
	endfunction

	function automatic vrad_pkg::cell_in_t char_beat(input logic rs, input logic [6:0] ch);
		vrad_pkg::cell_in_t b;
		b.row_start = rs;
		b.is_control = 1'b0;
		b.control_code = 5'($urandom_range(0, 31));
		b.cell_char = ch;
		return b;
	endfunction

	// Lean on mosaic colours and hold so that held mosaics show up often.
	function automatic logic [6:0] pick_code();
		if ($urandom_range(0, 3) != 0)
			return vrad_pkg::CODE_BASE + 7'($urandom_range(0, 31));
		case ($urandom_range(0, 3))
			0: return CODE_MOSAIC_BLACK + 7'($urandom_range(1, 7));
			1: return vrad_pkg::CODE_HOLD;
			2: return vrad_pkg::CODE_RELEASE;
			default: return $urandom_range(0, 1) ? vrad_pkg::CODE_SEPARATED
			                                     : vrad_pkg::CODE_CONTIG;
		endcase
	endfunction

	task automatic test_row_defaults();
		send_cell(char_beat(1'b1, 7'h7F));
		send_cell(char_beat(1'b0, 7'h00));
	endtask

	task automatic test_mosaic_hold();
		send_cell(control_beat(1'b1, CODE_MOSAIC_BLACK + 7'd1));
		send_cell(char_beat(1'b0, 7'h7F));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_SEPARATED));
		send_cell(char_beat(1'b0, 7'h20));
		send_cell(char_beat(1'b0, 7'h41));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_HOLD));
		send_cell(control_beat(1'b0, CODE_MOSAIC_BLACK + 7'd2));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_RELEASE));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_CONTIG));
	endtask

	task automatic test_colours();
		send_cell(control_beat(1'b1, vrad_pkg::CODE_BASE + 7'd3));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_NEW_BG));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_CONCEAL));
		send_cell(char_beat(1'b0, 7'h41));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_BLACK_BG));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_BASE));
		send_cell(char_beat(1'b0, 7'h5A));
	endtask

	task automatic test_flash_double();
		send_cell(control_beat(1'b1, vrad_pkg::CODE_FLASH));
		send_cell(char_beat(1'b0, 7'h33));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_STEADY));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_DOUBLE_HT));
		send_cell(control_beat(1'b0, CODE_END_BOX));
		send_cell(control_beat(1'b0, CODE_START_BOX));
		send_cell(control_beat(1'b0, CODE_SPARE_4E));
		send_cell(control_beat(1'b0, CODE_SPARE_4F));
		send_cell(control_beat(1'b0, CODE_ESCAPE));
		send_cell(control_beat(1'b0, vrad_pkg::CODE_NORMAL_HT));
		send_cell(char_beat(1'b1, 7'h2A));
	endtask

	task automatic test_random_rows(input int rows);
		int                 len;
		vrad_pkg::cell_in_t b;
		repeat (rows) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 40;
			for (int col = 0; col < len; col++) begin
				if ($urandom_range(0, 99) < 30)
					b = control_beat(col == 0, pick_code());
				else
					b = char_beat(col == 0, 7'($urandom_range(0, 127)));
				send_cell(b);
			end
		end
	endtask

	task automatic test_random_noise(input int count);
		vrad_pkg::cell_in_t b;
		repeat (count) begin
			b.row_start = 1'($urandom_range(0, 1));
			b.is_control = 1'($urandom_range(0, 1));
			b.control_code = 5'($urandom_range(0, 31));
			b.cell_char = 7'($urandom_range(0, 127));
			send_cell(b);
		end
	endtask

	// random stall bursts on the result side
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		vrad_pkg::cell_out_t got;
		vrad_pkg::cell_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{glyph_slot, mosaic_font, blink, fore_colour, back_colour, double_seen};
			if (expected_attrs.size() == 0) begin
				report_mismatch($sformatf("result beat with no cell pending, glyph %0h",
					got.glyph_slot));
			end else begin
				want = expected_attrs.pop_front();
				if (got.glyph_slot !== want.glyph_slot)
					report_mismatch($sformatf("glyph_slot %0h, want %0h",
						got.glyph_slot, want.glyph_slot));
				if (got.mosaic_font !== want.mosaic_font)
					report_mismatch($sformatf("mosaic_font %0b, want %0b",
						got.mosaic_font, want.mosaic_font));
				if (got.blink !== want.blink)
					report_mismatch($sformatf("blink %0b, want %0b", got.blink, want.blink));
				if (got.fore_colour !== want.fore_colour)
					report_mismatch($sformatf("fore_colour %0d, want %0d",
						got.fore_colour, want.fore_colour));
				if (got.back_colour !== want.back_colour)
					report_mismatch($sformatf("back_colour %0d, want %0d",
						got.back_colour, want.back_colour));
				if (got.double_seen !== want.double_seen)
					report_mismatch($sformatf("double_seen %0b, want %0b",
						got.double_seen, want.double_seen));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		cycles = 0;
		gap_pct = 20;
		stall_pct = 15;
		row_attr = vrad_pkg::ATTR_DEFAULTS;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		row_start <= 1'b0;
		is_control <= 1'b0;
		control_code <= '0;
		cell_char <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_row_defaults();
		test_mosaic_hold();
		test_colours();
		test_flash_double();
		test_random_rows(13);
		gap_pct = 35;
		stall_pct = 30;
		test_random_noise(150);
		// last part runs at full rate
		gap_pct = 0;
		stall_pct = 0;
		test_random_rows(4);
		in_valid <= 1'b0;

		while (expected_attrs.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### viewdata_row_attribute_decoder.f
+incdir+rtl/core
rtl/core/vrad_pkg.sv
rtl/core/vrad_cell_logic.sv
rtl/core/viewdata_row_attribute_decoder.sv
bench/viewdata_row_attribute_decoder_test.sv
